[rtl/pts_pkg.sv]
package pts_pkg;

   // phase word and default precisions
   localparam int PHASE_WIDTH           = 32;
   localparam int FRACTION_BITS_DEF     = 23;
   localparam int OUTPUT_FRAC_BITS_DEF  = 16;
   localparam int CONFIG_WIDTH          = 1;

   // internal fixed point is signed q2.30
   localparam int WORK_BITS  = 30;
   localparam int ACC_WIDTH  = 32;
   localparam int X_WIDTH    = 31;
   localparam int X2_WIDTH   = 32;

   localparam logic [X_WIDTH-1:0] HALF_PI_Q = 31'd1686629713;

   localparam logic signed [ACC_WIDTH-1:0] C3_Q     = -32'sd178956971;
   localparam logic signed [ACC_WIDTH-1:0] C5_Q     = 32'sd8947849;
   localparam logic signed [ACC_WIDTH-1:0] C7_Q     = -32'sd213045;
   localparam logic signed [ACC_WIDTH-1:0] C9_Q     = 32'sd2959;
   localparam logic signed [ACC_WIDTH-1:0] WORK_ONE = 32'sd1073741824;

   typedef logic signed [ACC_WIDTH-1:0] acc_type;

endpackage

[rtl/pts_if.sv]
interface pts_req_if import pts_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PHASE_WIDTH-1:0] phase;

   modport source (output valid, output phase, input ready);
   modport sink   (input valid, input phase, output ready);
endinterface

interface pts_rsp_if import pts_pkg::*; #(parameter int AMP_WIDTH = OUTPUT_FRAC_BITS_DEF + 2) ();
   logic                        valid;
   logic                        ready;
   logic signed [AMP_WIDTH-1:0] amplitude;

   modport source (output valid, output amplitude, input ready);
   modport sink   (input valid, input amplitude, output ready);
endinterface

interface pts_csr_if import pts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CONFIG_WIDTH-1:0] short_polynomial;

   modport source (output valid, output short_polynomial, input ready);
   modport sink   (input valid, input short_polynomial, output ready);
endinterface

[rtl/phase_to_sine_polynomial.sv]
// phase to sine converter, quarter-wave odd polynomial in fixed point
//
// req channel: one item per cycle unless rsp stalls, a 32-bit phase spanning one full turn
// rsp channel: one item per accepted phase, the sine in signed q2.OUTPUT_FRAC_BITS,
//    saturated to +-1.0
// csr channel: writes short_polynomial (0 = series through x^9, 1 = through x^7);
//    always ready, the setting is sampled with each item as it enters
//
// the pipeline takes one item per cycle while rsp is not stalled; each item passes
//    from req accept to rsp valid through eight register stages
//    (angle multiply, square, four horner steps, final multiply, truncate/saturate)
//
// reset clears every stage valid bit and the mode register (full polynomial)
// when rsp is stalled the whole pipeline holds, req.ready drops in the same
//    cycle, so nothing is lost or repeated
module phase_to_sine_polynomial
   import pts_pkg::*;
#(
   parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
   parameter int OUTPUT_FRAC_BITS = OUTPUT_FRAC_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   pts_req_if.sink      req,
   pts_rsp_if.source    rsp,
   pts_csr_if.sink      csr
);

   localparam int AMP_WIDTH  = OUTPUT_FRAC_BITS + 2;
   localparam int FULL_WIDTH = AMP_WIDTH + 1;
   localparam int PROD_WIDTH = FRACTION_BITS + X_WIDTH;
   localparam int S_WIDTH    = ACC_WIDTH + 1;
   localparam int FRAC_TOP   = PHASE_WIDTH - 3;
   localparam logic signed [FULL_WIDTH-1:0] LIM_POS = FULL_WIDTH'(1) << OUTPUT_FRAC_BITS;
   localparam logic signed [FULL_WIDTH-1:0] LIM_NEG = -LIM_POS;

   // one horner step: floor(a * x2 / 2^30) + c
   function automatic acc_type horner_step(input acc_type a,
                                           input logic [X2_WIDTH-1:0] x2,
                                           input acc_type c);
      logic signed [ACC_WIDTH+X2_WIDTH:0] p;
      p = a * $signed({1'b0, x2});
      return acc_type'(p[WORK_BITS+ACC_WIDTH-1:WORK_BITS]) + c;
   endfunction

   // mode register
   logic short_poly_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_poly_ff <= 1'b0;
      end else if (csr.valid) begin
         short_poly_ff <= csr.short_polynomial[0];
      end
   end

   assign csr.ready = 1'b1;

   // pipeline advances unless the output item is held by the receiver
   logic enable;
   logic [8:1] vld_ff;

   assign enable    = !(vld_ff[8] && !rsp.ready);
   assign req.ready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[7:1], req.valid};
      end
   end

   // stage 1: fold the quarter wave, scale the fraction by pi/2
   logic [FRACTION_BITS-1:0] frac;
   logic [PROD_WIDTH-1:0]    angle_prod;
   logic [X_WIDTH-1:0]       x1_in, x1_ff;
   logic                     neg1_ff, mode1_ff;

   always_comb begin
      frac = req.phase[FRAC_TOP -: FRACTION_BITS];
      if (req.phase[PHASE_WIDTH-2]) begin
         frac = ~frac;
      end
      angle_prod = frac * HALF_PI_Q;
      x1_in      = angle_prod[PROD_WIDTH-1:FRACTION_BITS];
   end

   // stage 2: x squared
   logic [2*X_WIDTH-1:0] sq_prod;
   logic [X2_WIDTH-1:0]  x2_2_in, x2_2_ff;
   logic [X_WIDTH-1:0]   x2_ff;
   logic                 neg2_ff, mode2_ff;

   assign sq_prod = x1_ff * x1_ff;
   assign x2_2_in = sq_prod[WORK_BITS+X2_WIDTH-1:WORK_BITS];

   // stages 3..6: horner in x^2, the x^9 term skipped in short mode
   acc_type acc3_in, acc3_ff, acc4_in, acc4_ff, acc5_in, acc5_ff, acc6_in, acc6_ff;
   logic [X2_WIDTH-1:0] sq3_ff, sq4_ff, sq5_ff;
   logic [X_WIDTH-1:0]  x3_ff, x4_ff, x5_ff, x6_ff;
   logic [6:3]          neg_ff;

   assign acc3_in = mode2_ff ? C7_Q : horner_step(C9_Q, x2_2_ff, C7_Q);
   assign acc4_in = horner_step(acc3_ff, sq3_ff, C5_Q);
   assign acc5_in = horner_step(acc4_ff, sq4_ff, C3_Q);
   assign acc6_in = horner_step(acc5_ff, sq5_ff, WORK_ONE);

   // stage 7: multiply by x for the odd series
   logic signed [ACC_WIDTH+X_WIDTH:0] fin_prod;
   logic signed [S_WIDTH-1:0]         s7_in, s7_ff;
   logic                              neg7_ff;

   assign fin_prod = acc6_ff * $signed({1'b0, x6_ff});
   assign s7_in    = fin_prod[WORK_BITS+S_WIDTH-1:WORK_BITS];

   // stage 8: truncate to output precision, saturate, apply the half-turn sign
   logic signed [FULL_WIDTH-1:0] amp_full, amp_sat;
   logic signed [AMP_WIDTH-1:0]  amp_in, amp_ff;

   always_comb begin
      amp_full = s7_ff[S_WIDTH-1 : WORK_BITS-OUTPUT_FRAC_BITS];
      if (amp_full > LIM_POS) begin
         amp_sat = LIM_POS;
      end else if (amp_full < LIM_NEG) begin
         amp_sat = LIM_NEG;
      end else begin
         amp_sat = amp_full;
      end
      amp_in = neg7_ff ? AMP_WIDTH'(-amp_sat) : AMP_WIDTH'(amp_sat);
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (enable) begin
         x1_ff    <= x1_in;
         neg1_ff  <= req.phase[PHASE_WIDTH-1];
         mode1_ff <= short_poly_ff;

         x2_2_ff  <= x2_2_in;
         x2_ff    <= x1_ff;
         neg2_ff  <= neg1_ff;
         mode2_ff <= mode1_ff;

         acc3_ff  <= acc3_in;
         sq3_ff   <= x2_2_ff;
         x3_ff    <= x2_ff;
         neg_ff   <= {neg_ff[5:3], neg2_ff};

         acc4_ff  <= acc4_in;
         sq4_ff   <= sq3_ff;
         x4_ff    <= x3_ff;

         acc5_ff  <= acc5_in;
         sq5_ff   <= sq4_ff;
         x5_ff    <= x4_ff;

         acc6_ff  <= acc6_in;
         x6_ff    <= x5_ff;

         s7_ff    <= s7_in;
         neg7_ff  <= neg_ff[6];

         amp_ff   <= amp_in;
      end
   end

   assign rsp.valid     = vld_ff[8];
   assign rsp.amplitude = amp_ff;

endmodule

[tb/sine_checker.sv]
module sine_checker (
   input  logic clock,
   input  logic reset,
   pts_req_if   req,
   pts_rsp_if   rsp,
   pts_csr_if   csr,
   output int   error_count,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC_BITS = 23;
   localparam int     OUT_FRAC  = 16;
   localparam int     AMP_W     = OUT_FRAC + 2;
   localparam int     Q_BITS    = 30;
   localparam longint HALF_PI   = 64'sd1686629713;
   localparam longint COEF_3    = -64'sd178956971;
   localparam longint COEF_5    = 64'sd8947849;
   localparam longint COEF_7    = -64'sd213045;
   localparam longint COEF_9    = 64'sd2959;
   localparam longint Q_ONE     = 64'sd1 << Q_BITS;
   localparam longint AMP_LIM   = 64'sd1 << OUT_FRAC;

   typedef struct {
      logic [31:0]              phase;
      logic signed [AMP_W-1:0]  amplitude;
   } sample_type;

   sample_type expected_samples[$];
   sample_type head;
   bit         short_mode;

   // q2.30 product, floored back to 30 fraction bits
   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b) >>> Q_BITS;
   endfunction

   function automatic logic signed [AMP_W-1:0] sine_of_phase(input logic [31:0] phase,
                                                             input bit short_poly);
      logic [FRAC_BITS-1:0] frac;
      longint               angle;
      longint               angle_sq;
      longint               horner;
      longint               amp;
      frac = phase[29:30-FRAC_BITS];
      // second and fourth quarter run the quarter wave backwards
      if (phase[30]) frac = ~frac;
      angle    = (longint'(frac) * HALF_PI) >>> FRAC_BITS;
      angle_sq = q30_mul(angle, angle);
      if (short_poly) horner = COEF_7;
      else horner = q30_mul(COEF_9, angle_sq) + COEF_7;
      horner = q30_mul(horner, angle_sq) + COEF_5;
      horner = q30_mul(horner, angle_sq) + COEF_3;
      horner = q30_mul(horner, angle_sq) + Q_ONE;
      amp    = q30_mul(horner, angle) >>> (Q_BITS - OUT_FRAC);
      if (amp > AMP_LIM) amp = AMP_LIM;
      if (amp < -AMP_LIM) amp = -AMP_LIM;
      if (phase[31]) amp = -amp;
      return amp[AMP_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         short_mode  <= 1'b0;
         error_count = 0;
         checked     = 0;
         pending     = 0;
      end else begin
         if (csr.valid && csr.ready) short_mode <= csr.short_polynomial[0];
         if (req.valid && req.ready)
            expected_samples.push_back('{req.phase, sine_of_phase(req.phase, short_mode)});
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               $error("amplitude: unexpected item, got %0d", rsp.amplitude);
               error_count++;
            end else begin
               head = expected_samples.pop_front();
               checked++;
               if (rsp.amplitude !== head.amplitude) begin
                  $error("amplitude mismatch for phase 0x%08h: expected %0d, actual %0d",
                         head.phase, head.amplitude, rsp.amplitude);
                  error_count++;
               end
            end
         end
         pending = expected_samples.size();
      end
   end

endmodule

[tb/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     PIPE_LATENCY = 8;
   localparam int     PHASE_ITEMS  = 60;
   localparam int     HOLD_CYCLES  = 64;
   localparam bit     FULL_SERIES  = 1'b0;
   localparam bit     SHORT_SERIES = 1'b1;

   logic clock = 1'b0;
   logic reset;

   pts_req_if req_ch ();
   pts_rsp_if rsp_ch ();
   pts_csr_if csr_ch ();

   int chk_errors;
   int chk_pending;
   int chk_checked;

   // pacing knobs, read by the sender task and the receiver process
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int sent_count     = 0;
   int cycle_count    = 0;

   // per-phase pacing: no idling, sender idle, receiver stall, both
   int send_idle_tbl[4]  = '{0, 79, 0, 12};
   int recv_stall_tbl[4] = '{0, 0, 79, 12};

   // corners of the phase word: quadrant edges, quarter-turn saturation,
   // ignored low bits, fraction lsb, octants
   logic [31:0] corner_phases[12] = '{
      32'h0000_0000, 32'hffff_ffff, 32'h4000_0000, 32'h3fff_ffff,
      32'h8000_0000, 32'hc000_0000, 32'h7fff_ffff, 32'hbfff_ffff,
      32'h0000_007f, 32'h0000_0080, 32'h2000_0000, 32'he000_0000
   };

   always #10 clock = ~clock;

   phase_to_sine_polynomial dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   sine_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .error_count (chk_errors),
      .pending     (chk_pending),
      .checked     (chk_checked)
   );

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count, chk_pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off counted down here
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_phase(input logic [31:0] phase);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.phase <= phase;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
      @(negedge clock);
   endtask

   // wait for every expected item, then let the pipeline settle
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (chk_pending != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 2) @(negedge clock);
   endtask

   // mode write, only issued with the pipeline empty
   task automatic write_mode(input bit mode);
      csr_ch.valid            <= 1'b1;
      csr_ch.short_polynomial <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly uniform phases, with extra weight near the quadrant edges
   function automatic logic [31:0] pick_phase();
      logic [1:0] quadrant;
      quadrant = 2'($urandom_range(3));
      case ($urandom_range(9))
         0: begin
            return {quadrant, 30'h3fff_ffff - 30'($urandom_range(4095))};
         end
         1: begin
            return {quadrant, 30'($urandom_range(4095))};
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   initial begin
      // every input known from time zero
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.phase            = '0;
      rsp_ch.ready            = 1'b0;
      csr_ch.valid            = 1'b0;
      csr_ch.short_polynomial = '0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners under light pacing, once per series length
      send_idle_pct  = 12;
      recv_stall_pct = 12;
      write_mode(FULL_SERIES);
      foreach (corner_phases[i]) send_phase(corner_phases[i]);
      drain_pipeline();
      write_mode(SHORT_SERIES);
      foreach (corner_phases[i]) send_phase(corner_phases[i]);
      drain_pipeline();

      // random phases: each pacing mode with both series lengths
      for (int k = 0; k < 8; k++) begin
         send_idle_pct  = send_idle_tbl[k / 2];
         recv_stall_pct = recv_stall_tbl[k / 2];
         write_mode(k[0] ? SHORT_SERIES : FULL_SERIES);
         repeat (PHASE_ITEMS) send_phase(pick_phase());
         drain_pipeline();
      end

      // back-pressure: output held off while the sender keeps offering,
      // so the pipeline fills and req.ready drops
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_mode(FULL_SERIES);
      hold_left = HOLD_CYCLES;
      repeat (40) send_phase(pick_phase());
      drain_pipeline();

      $display("sent %0d phases, checked %0d amplitudes, errors %0d", sent_count,
               chk_checked, chk_errors);
      $display("covered quadrant corners, both series lengths, four pacing mixes and a long stall");
      if (chk_errors == 0 && chk_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
